>>> rtl/core/sai_pkg.sv
package sai_pkg;

    typedef enum logic [2:0] {
        OP_SEARCH  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_CLEAR   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    issue;
        logic    probe;
        logic    shift_start;
        logic    shift_run;
        logic    write_new;
        logic    write_replace;
        logic    write_overwrite;
        logic    count_inc;
        logic    count_dec;
        logic    count_clear;
        logic    finish;
        logic    report;
        status_t status;
    } sai_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t op;
        logic    locked;
        logic    search_open;
        logic    probe_eq;
        logic    probe_open;
        logic    found;
        logic    full;
        logic    slot_in_range;
        logic    pos_below_last;
        logic    tpos_valid;
        logic    shift_last;
    } sai_stat_t;

endpackage

>>> rtl/core/sai_ram.sv
module sai_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 64
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/sai_ctrl.sv
module sai_ctrl
    import sai_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      start,
        input  sai_stat_t stat,
        output sai_cmd_t  cmd,
        output logic      busy,
        output logic      done
    );

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PROBE,
        S_LOCATED,
        S_SHIFT_START,
        S_SHIFT_RUN,
        S_WRITE_NEW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op) inside
                    OP_SEARCH, OP_INSERT, OP_REMOVE:
                    begin
                        if (stat.op != OP_SEARCH && stat.locked)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_BUSY;
                            state_next = S_IDLE;
                        end
                        else if (stat.search_open)
                        begin
                            cmd.issue  = 1'b1;
                            state_next = S_PROBE;
                        end
                        else
                        begin
                            state_next = S_LOCATED;
                        end
                    end
                    OP_REPLACE:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                        if (stat.tpos_valid)
                        begin
                            cmd.write_replace = 1'b1;
                        end
                        else
                        begin
                            cmd.status = ST_BAD_POS;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.count_clear = 1'b1;
                        cmd.finish      = 1'b1;
                        state_next      = S_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_BAD_POS;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                if (stat.probe_eq || !stat.probe_open)
                begin
                    state_next = S_LOCATED;
                end
            end
            S_LOCATED:
            begin
                unique case (stat.op)
                    OP_SEARCH:
                    begin
                        cmd.finish = 1'b1;
                        cmd.report = stat.found;
                        cmd.status = stat.found ? ST_OK : ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    OP_INSERT:
                    begin
                        if (stat.found)
                        begin
                            cmd.write_overwrite = 1'b1;
                            cmd.finish          = 1'b1;
                            cmd.report          = 1'b1;
                            state_next          = S_IDLE;
                        end
                        else if (stat.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_NO_SPACE;
                            state_next = S_IDLE;
                        end
                        else if (stat.slot_in_range)
                        begin
                            state_next = S_SHIFT_START;
                        end
                        else
                        begin
                            state_next = S_WRITE_NEW;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.found)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                        else if (stat.pos_below_last)
                        begin
                            state_next = S_SHIFT_START;
                        end
                        else
                        begin
                            cmd.count_dec = 1'b1;
                            cmd.finish    = 1'b1;
                            cmd.report    = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_BAD_POS;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_START:
            begin
                cmd.shift_start = 1'b1;
                state_next      = S_SHIFT_RUN;
            end
            S_SHIFT_RUN:
            begin
                cmd.shift_run = 1'b1;
                if (stat.shift_last)
                begin
                    if (stat.op == OP_INSERT)
                    begin
                        state_next = S_WRITE_NEW;
                    end
                    else
                    begin
                        cmd.count_dec = 1'b1;
                        cmd.finish    = 1'b1;
                        cmd.report    = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_WRITE_NEW:
            begin
                cmd.write_new = 1'b1;
                cmd.count_inc = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

endmodule

>>> rtl/core/sai_dpath.sv
module sai_dpath
    import sai_pkg::*;
    #(
        parameter int CAPACITY   = 64,
        parameter int KEY_BITS   = 32,
        parameter int VALUE_BITS = 32,
        parameter int POS_W      = $clog2(CAPACITY),
        parameter int CNT_W      = $clog2(CAPACITY + 1)
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  sai_cmd_t              cmd,
        output sai_stat_t             stat,
        input  logic                  cfg_valid,
        input  logic                  cfg_data,
        input  logic [2:0]            opcode,
        input  logic [KEY_BITS-1:0]   entry_key,
        input  logic [VALUE_BITS-1:0] entry_value,
        input  logic                  overwrite,
        input  logic [POS_W-1:0]      target_position,
        output logic [2:0]            status,
        output logic                  hit,
        output logic [KEY_BITS-1:0]   found_key,
        output logic [VALUE_BITS-1:0] found_value,
        output logic [POS_W-1:0]      found_position,
        output logic [CNT_W-1:0]      count_after
    );

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    // Request registers.
    logic [2:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  ow_reg;
    logic [POS_W-1:0]      tpos_reg;

    // Search window [lo, hi1) and located entry.
    logic [CNT_W-1:0]      lo_reg;
    logic [CNT_W-1:0]      lo_next;
    logic [CNT_W-1:0]      hi1_reg;
    logic [CNT_W-1:0]      hi1_next;
    logic [POS_W-1:0]      addr_reg;
    logic [POS_W-1:0]      addr_next;
    logic                  found_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [KEY_BITS-1:0]   fkey_reg;
    logic [VALUE_BITS-1:0] fval_reg;

    logic [CNT_W-1:0]      count_reg;
    logic                  lock_reg;

    // Result registers.
    status_t               status_reg;
    logic                  hit_reg;
    logic [KEY_BITS-1:0]   rkey_reg;
    logic [VALUE_BITS-1:0] rval_reg;
    logic [POS_W-1:0]      rpos_reg;

    // Memory ports.
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic                  key_we;
    logic                  val_we;
    logic [POS_W-1:0]      waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [VALUE_BITS-1:0] val_wdata;

    logic [CNT_W:0]        sum_cur;
    logic [CNT_W:0]        sum_next;
    logic [POS_W-1:0]      mid_cur;
    logic [POS_W-1:0]      mid_next;
    logic                  key_gt;
    logic                  key_lt;
    logic                  shift_up;
    logic [POS_W-1:0]      last_pos;

    assign shift_up = (op_reg == OP_INSERT);
    assign last_pos = POS_W'(count_reg - CNT_W'(1));

    assign key_gt = (key_reg > key_rdata);
    assign key_lt = (key_reg < key_rdata);

    always_comb
    begin
        lo_next  = key_gt ? (CNT_W'(addr_reg) + CNT_W'(1)) : lo_reg;
        hi1_next = key_lt ? CNT_W'(addr_reg) : hi1_reg;
    end

    // Midpoint of [lo, hi1 - 1]; only used while the window is open.
    assign sum_cur  = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CNT_W+1)'(1);
    assign sum_next = {1'b0, lo_next} + {1'b0, hi1_next} - (CNT_W+1)'(1);
    assign mid_cur  = sum_cur[POS_W:1];
    assign mid_next = sum_next[POS_W:1];

    always_comb
    begin
        if (cmd.issue)
        begin
            addr_next = mid_cur;
        end
        else if (cmd.probe)
        begin
            addr_next = mid_next;
        end
        else if (cmd.shift_start)
        begin
            addr_next = shift_up ? last_pos : (pos_reg + POS_W'(1));
        end
        else if (cmd.shift_run)
        begin
            addr_next = shift_up ? (addr_reg - POS_W'(1)) : (addr_reg + POS_W'(1));
        end
        else
        begin
            addr_next = addr_reg;
        end
    end

    always_comb
    begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        waddr     = addr_reg;
        key_wdata = key_reg;
        val_wdata = val_reg;
        if (cmd.shift_run)
        begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            waddr     = shift_up ? (addr_reg + POS_W'(1)) : (addr_reg - POS_W'(1));
            key_wdata = key_rdata;
            val_wdata = val_rdata;
        end
        else if (cmd.write_new)
        begin
            key_we = 1'b1;
            val_we = 1'b1;
            waddr  = lo_reg[POS_W-1:0];
        end
        else if (cmd.write_replace)
        begin
            key_we = 1'b1;
            val_we = 1'b1;
            waddr  = tpos_reg;
        end
        else if (cmd.write_overwrite)
        begin
            val_we = ow_reg;
            waddr  = pos_reg;
        end
    end

    sai_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram
    (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (addr_next),
        .rdata (key_rdata)
    );

    sai_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram
    (
        .clk   (clk),
        .we    (val_we),
        .waddr (waddr),
        .wdata (val_wdata),
        .raddr (addr_next),
        .rdata (val_rdata)
    );

    always_comb
    begin
        stat.op             = opcode_t'(op_reg);
        stat.locked         = lock_reg;
        stat.search_open    = (lo_reg < hi1_reg);
        stat.probe_eq       = !key_gt && !key_lt;
        stat.probe_open     = (lo_next < hi1_next);
        stat.found          = found_reg;
        stat.full           = (count_reg >= CAP_COUNT);
        stat.slot_in_range  = (lo_reg < count_reg);
        stat.pos_below_last = ((CNT_W'(pos_reg) + CNT_W'(1)) < count_reg);
        stat.tpos_valid     = (CNT_W'(tpos_reg) < count_reg);
        stat.shift_last     = shift_up ? (CNT_W'(addr_reg) == lo_reg)
                                       : (addr_reg == last_pos);
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.load)
        begin
            op_reg   <= opcode;
            key_reg  <= entry_key;
            val_reg  <= entry_value;
            ow_reg   <= overwrite;
            tpos_reg <= target_position;
            lo_reg   <= '0;
            hi1_reg  <= count_reg;
        end
        else if (cmd.probe)
        begin
            lo_reg  <= lo_next;
            hi1_reg <= hi1_next;
            if (stat.probe_eq)
            begin
                pos_reg  <= addr_reg;
                fkey_reg <= key_rdata;
                fval_reg <= val_rdata;
            end
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            hit_reg    <= cmd.report;
            rkey_reg   <= cmd.report ? fkey_reg : '0;
            rval_reg   <= cmd.report ? fval_reg : '0;
            rpos_reg   <= cmd.report ? pos_reg : '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            count_reg <= '0;
            lock_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                lock_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.probe && stat.probe_eq)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign status         = status_reg;
    assign hit            = hit_reg;
    assign found_key      = rkey_reg;
    assign found_value    = rval_reg;
    assign found_position = rpos_reg;
    assign count_after    = count_reg;

endmodule

>>> rtl/core/sorted_array_index_unit.sv
// Sorted key/value table with binary search. The table holds up to CAPACITY
// entries in ascending unsigned key order and serves one request at a time:
// search, insert, remove, replace at a position, or clear. A request transfers
// at a rising edge with start high and busy low; its single result appears on
// the result ports for exactly one cycle with done high, and the receiver cannot
// stall it, so capture it in that cycle. Busy is already low in the done cycle,
// so the next request may transfer there. Replace, clear, a locked insert or
// remove and an unknown opcode finish straight from decode; a search makes P
// probes, where P is at most floor(log2(count)) + 1 (7 for a full table of
// 64). In each probe the key memory's registered read feeds the compare,
// which picks the next midpoint address. An insert of a new key first moves
// the entries at and above its slot up, then writes the key, and a remove
// moves the entries above the removed one down; entries move one per cycle
// through the single read and write port of each memory. A present key on
// insert finishes like a search. The table needs no clearing after reset, since
// entries at or beyond the count are never read. The lock register is written
// through the cfg channel, which is always ready.
module sorted_array_index_unit
    import sai_pkg::*;
    #(
        parameter int CAPACITY   = 64,
        parameter int KEY_BITS   = 32,
        parameter int VALUE_BITS = 32
    )
    (
        input  logic                           clk,
        input  logic                           rst_n,
        input  logic                           start,
        output logic                           busy,
        input  logic [2:0]                     opcode,
        input  logic [KEY_BITS-1:0]            entry_key,
        input  logic [VALUE_BITS-1:0]          entry_value,
        input  logic                           overwrite,
        input  logic [$clog2(CAPACITY)-1:0]    target_position,
        output logic                           done,
        output logic [2:0]                     status,
        output logic                           hit,
        output logic [KEY_BITS-1:0]            found_key,
        output logic [VALUE_BITS-1:0]          found_value,
        output logic [$clog2(CAPACITY)-1:0]    found_position,
        output logic [$clog2(CAPACITY+1)-1:0]  count_after,
        input  logic                           cfg_valid,
        output logic                           cfg_ready,
        input  logic                           cfg_data
    );

    sai_cmd_t  cmd;
    sai_stat_t stat;

    // The lock register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences decode, probing, shifting and the final write.
    sai_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the request, the search window, both memories, the
    // entry count, the lock and the result registers.
    sai_dpath
    #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .entry_key       (entry_key),
        .entry_value     (entry_value),
        .overwrite       (overwrite),
        .target_position (target_position),
        .status          (status),
        .hit             (hit),
        .found_key       (found_key),
        .found_value     (found_value),
        .found_position  (found_position),
        .count_after     (count_after)
    );

endmodule

>>> rtl/core/sai_checker.sv
module sai_checker
    import sai_pkg::*;
    #(
        parameter int CAPACITY = 64
    )
    (
        input logic                          clk,
        input logic                          rst_n,
        input logic                          start,
        input logic                          busy,
        input logic                          done,
        input logic [2:0]                    status,
        input logic                          hit,
        input logic [$clog2(CAPACITY+1)-1:0] count_after
    );

    localparam logic [$clog2(CAPACITY+1)-1:0] CAP_COUNT = ($clog2(CAPACITY+1))'(CAPACITY);

    // A transferred request always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer not followed by busy");

    // A result ends a busy period and frees the request side at once.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a busy period");

    // A hit is only reported with status ok.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == ST_OK))
        else $error("hit reported with a failing status");

    // At every result, the entry count does not exceed the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_after <= CAP_COUNT))
        else $error("entry count beyond capacity");

endmodule

bind sorted_array_index_unit sai_checker #(.CAPACITY(CAPACITY)) u_sai_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .hit         (hit),
    .count_after (count_after)
);

>>> verif/sorted_array_index_unit_tb.sv
module sorted_array_index_unit_tb
    import sai_pkg::*;
    ();

    timeunit 1ns;
    timeprecision 1ps;

    // Table geometry, matching the default parameters of the unit.
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;

    // Run control.
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASES        = 8;
    localparam int PRINT_LIMIT   = 100;

    // Opcode values that the package leaves unnamed; the unit rejects them with bad position.
    localparam int OP_SPARE_FIRST = 5;
    localparam int OP_SPARE_LAST  = 7;

    // One expected result, laid out field by field like the result ports.
    typedef struct packed {
        status_t             status;
        logic                hit;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
    } table_result_t;

    // Every input of the unit starts from a known value.
    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 start           = 1'b0;
    logic [2:0]           opcode          = OP_SEARCH;
    logic [KEY_W-1:0]     entry_key       = '0;
    logic [VAL_W-1:0]     entry_value     = '0;
    logic                 overwrite       = 1'b0;
    logic [POS_W-1:0]     target_position = '0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_data        = 1'b0;

    logic                 busy;
    logic                 done;
    logic [2:0]           status;
    logic                 hit;
    logic [KEY_W-1:0]     found_key;
    logic [VAL_W-1:0]     found_value;
    logic [POS_W-1:0]     found_position;
    logic [CNT_W-1:0]     count_after;
    logic                 cfg_ready;

    // The testbench's own image of the table, the count and the lock register.
    logic [KEY_W-1:0]     model_key [CAPACITY];
    logic [VAL_W-1:0]     model_val [CAPACITY];
    int                   model_count = 0;
    bit                   model_lock  = 1'b0;

    // Results predicted for accepted requests, oldest first.
    table_result_t        pending_results [$];

    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   idle_on     = 1'b1;

    always #CLK_HALF clk = ~clk;

    sorted_array_index_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .entry_key       (entry_key),
        .entry_value     (entry_value),
        .overwrite       (overwrite),
        .target_position (target_position),
        .done            (done),
        .status          (status),
        .hit             (hit),
        .found_key       (found_key),
        .found_value     (found_value),
        .found_position  (found_position),
        .count_after     (count_after),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // Binary search over the table exactly as it stands, which may be out of
    // order after a replace. Returns the position of the key or -1, and gives
    // the place where a new key would go in slot.
    function automatic int bsearch_slot(input logic [KEY_W-1:0] key, output int slot);
        int lo;
        int hi;
        int mid;
        int dir;
        lo   = 0;
        hi   = model_count - 1;
        mid  = 0;
        dir  = 0;
        slot = 0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key > model_key[mid])
            begin
                dir = 1;
                lo  = mid + 1;
            end
            else if (key < model_key[mid])
            begin
                dir = -1;
                hi  = mid - 1;
            end
            else
            begin
                slot = mid;
                return mid;
            end
        end
        slot = (dir > 0) ? mid + 1 : mid;
        return -1;
    endfunction

    // Applies one request to the table image and returns the result that the
    // unit must produce for it.
    function automatic table_result_t table_apply(
        input logic [2:0]       op,
        input logic [KEY_W-1:0] key,
        input logic [VAL_W-1:0] val,
        input logic             ow,
        input logic [POS_W-1:0] tpos
    );
        table_result_t r;
        int            pos;
        int            slot;
        int            i;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_SEARCH:
            begin
                pos = bsearch_slot(key, slot);
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.hit   = 1'b1;
                    r.key   = model_key[pos];
                    r.value = model_val[pos];
                    r.pos   = pos[POS_W-1:0];
                end
            end
            OP_INSERT:
            begin
                if (model_lock)
                    r.status = ST_BUSY;
                else
                begin
                    pos = bsearch_slot(key, slot);
                    if (pos >= 0)
                    begin
                        // A present key reports the value from before any overwrite.
                        r.hit   = 1'b1;
                        r.key   = model_key[pos];
                        r.value = model_val[pos];
                        r.pos   = pos[POS_W-1:0];
                        if (ow)
                            model_val[pos] = val;
                    end
                    else if (model_count >= CAPACITY)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        for (i = model_count; i > slot; i--)
                        begin
                            model_key[i] = model_key[i-1];
                            model_val[i] = model_val[i-1];
                        end
                        model_key[slot] = key;
                        model_val[slot] = val;
                        model_count++;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (model_lock)
                    r.status = ST_BUSY;
                else
                begin
                    pos = bsearch_slot(key, slot);
                    if (pos < 0)
                        r.status = ST_NOT_FOUND;
                    else
                    begin
                        r.hit   = 1'b1;
                        r.key   = model_key[pos];
                        r.value = model_val[pos];
                        r.pos   = pos[POS_W-1:0];
                        model_count--;
                        for (i = pos; i < model_count; i++)
                        begin
                            model_key[i] = model_key[i+1];
                            model_val[i] = model_val[i+1];
                        end
                    end
                end
            end
            OP_REPLACE:
            begin
                if (int'(tpos) >= model_count)
                    r.status = ST_BAD_POS;
                else
                begin
                    model_key[tpos] = key;
                    model_val[tpos] = val;
                end
            end
            OP_CLEAR:
                model_count = 0;
            default:
                r.status = ST_BAD_POS;
        endcase
        r.count = model_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Result checker. The receiver cannot stall the unit, so every cycle with
    // done high is one result transfer, compared against the oldest prediction.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_error("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_error($sformatf("status %0d, expected %0d", status, want.status));
                if (hit !== want.hit)
                    report_error($sformatf("hit %0b, expected %0b", hit, want.hit));
                if (found_key !== want.key)
                    report_error($sformatf("found_key %h, expected %h", found_key, want.key));
                if (found_value !== want.value)
                    report_error($sformatf("found_value %h, expected %h",
                                           found_value, want.value));
                if (found_position !== want.pos)
                    report_error($sformatf("found_position %0d, expected %0d",
                                           found_position, want.pos));
                if (count_after !== want.count)
                    report_error($sformatf("count_after %0d, expected %0d",
                                           count_after, want.count));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_array_index_unit_tb failed");
            $finish;
        end
    end

    // Sends one request. It is always entered right after a rising edge. Start
    // is left high after the transfer so that a following request can go out
    // back to back; a random idle burst, or wait_idle, lowers it.
    task automatic send_item(
        input logic [2:0]       op,
        input logic [KEY_W-1:0] key,
        input logic [VAL_W-1:0] val,
        input logic             ow,
        input logic [POS_W-1:0] tpos
    );
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        opcode          <= op;
        entry_key       <= key;
        entry_value     <= val;
        overwrite       <= ow;
        target_position <= tpos;
        // The transfer happens at the first edge that sees busy low.
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(table_apply(op, key, val, ow, tpos));
    endtask

    // Drops start and waits until every outstanding result has come back. Every
    // request produces a result, so the unit is idle once the queue is empty.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the lock register; only ever done while the unit is idle.
    task automatic write_lock(input bit value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        model_lock = value;
        cfg_valid <= 1'b0;
    endtask

    // Key choice for random traffic: half the time keys already in the table, so that
    // hits, overwrites and removes are common, plus extremes and a narrow range
    // that collides often.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (model_count > 0 && sel < 5)
            return model_key[$urandom_range(0, model_count - 1)];
        if (sel == 5)
            return '0;
        if (sel == 6)
            return '1;
        if (sel == 7)
            return KEY_W'($urandom_range(0, 31));
        return $urandom;
    endfunction

    // One random request. grow_pct sets how often the table-changing requests
    // are inserts rather than removes, which steers the count up or down.
    task automatic random_item(input int grow_pct);
        int              roll;
        logic [2:0]      op;
        logic [POS_W-1:0] tpos;
        logic [KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        tpos = POS_W'($urandom_range(0, CAPACITY - 1));
        key  = pick_key();
        if (roll < 1)
            op = OP_CLEAR;
        else if (roll < 3)
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else if (roll < 25)
            op = OP_SEARCH;
        else if (roll < 35)
        begin
            op = OP_REPLACE;
            if (model_count > 0 && $urandom_range(0, 4) != 0)
            begin
                tpos = POS_W'($urandom_range(0, model_count - 1));
                // Usually keep the key so the table stays in order; sometimes not.
                if ($urandom_range(0, 9) < 7)
                    key = model_key[tpos];
            end
        end
        else if ($urandom_range(0, 99) < grow_pct)
            op = OP_INSERT;
        else
            op = OP_REMOVE;
        send_item(op, key, $urandom, 1'($urandom_range(0, 1)), tpos);
    endtask

    // Directed pass over every operation and the edge cases: empty table,
    // lowest and highest keys, present key with and without overwrite, replace
    // inside and outside the count, the unused opcodes and clear.
    task automatic test_directed();
        send_item(OP_SEARCH,  32'h0000_0000, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
        send_item(OP_INSERT,  32'h8000_0000, 32'h1234_5678, 1'b0, '0);
        send_item(OP_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '1);
        send_item(OP_INSERT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '0);
        send_item(OP_INSERT,  32'h4000_0000, 32'hA5A5_A5A5, 1'b0, '0);
        send_item(OP_INSERT,  32'h8000_0000, 32'hDEAD_BEEF, 1'b0, '0);
        send_item(OP_INSERT,  32'h8000_0000, 32'hCAFE_F00D, 1'b1, '0);
        send_item(OP_SEARCH,  32'h8000_0000, 32'h0000_0000, 1'b0, '0);
        send_item(OP_SEARCH,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
        send_item(OP_SEARCH,  32'h0000_0000, 32'h0000_0000, 1'b0, '0);
        send_item(OP_SEARCH,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REPLACE, 32'h0000_0001, 32'h5555_5555, 1'b0, 6'd0);
        send_item(OP_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd4);
        send_item(OP_REPLACE, 32'h0000_0002, 32'h0000_0002, 1'b0, '1);
        send_item(OP_REMOVE,  32'h4000_0000, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REMOVE,  32'h4000_0000, 32'h0000_0000, 1'b0, '0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_item(3'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1);
        send_item(OP_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1);
        send_item(OP_SEARCH,  32'h0000_0001, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REMOVE,  32'h0000_0001, 32'h0000_0000, 1'b0, '0);
    endtask

    // With the lock set, insert and remove must come back busy while search,
    // replace and clear still work.
    task automatic test_lock_register();
        send_item(OP_INSERT,  32'd10, 32'h0000_0A0A, 1'b0, '0);
        send_item(OP_INSERT,  32'd20, 32'h0000_1414, 1'b0, '0);
        write_lock(1'b1);
        send_item(OP_INSERT,  32'd30, 32'h0000_1E1E, 1'b0, '0);
        send_item(OP_INSERT,  32'd10, 32'hFFFF_FFFF, 1'b1, '0);
        send_item(OP_REMOVE,  32'd10, 32'h0000_0000, 1'b0, '0);
        send_item(OP_SEARCH,  32'd10, 32'h0000_0000, 1'b0, '0);
        send_item(OP_REPLACE, 32'd15, 32'h0000_0F0F, 1'b0, 6'd1);
        send_item(OP_SEARCH,  32'd15, 32'h0000_0000, 1'b0, '0);
        send_item(OP_CLEAR,   32'd0,  32'h0000_0000, 1'b0, '0);
        write_lock(1'b0);
        send_item(OP_INSERT,  32'd30, 32'h0000_1E1E, 1'b0, '0);
    endtask

    // Fills the table to capacity with random keys, then checks the full-table
    // cases: a new key gets no space, a present key still hits and overwrites.
    task automatic test_full_table();
        send_item(OP_CLEAR, '0, '0, 1'b0, '0);
        while (model_count < CAPACITY)
            send_item(OP_INSERT, $urandom, $urandom, 1'($urandom_range(0, 1)), '0);
        send_item(OP_INSERT, $urandom, $urandom, 1'b0, '0);
        send_item(OP_INSERT, model_key[CAPACITY/2], $urandom, 1'b1, '0);
        send_item(OP_SEARCH, model_key[CAPACITY/2], '0, 1'b0, '0);
        send_item(OP_SEARCH, model_key[CAPACITY-1], '0, 1'b0, '0);
        send_item(OP_REPLACE, model_key[CAPACITY-1], $urandom, 1'b0, 6'(CAPACITY - 1));
        send_item(OP_REMOVE, model_key[0], '0, 1'b0, '0);
        send_item(OP_INSERT, $urandom, $urandom, 1'b0, '0);
    endtask

    // Random traffic in phases. Each phase sets the lock, chooses whether the
    // sender idles, and leans toward growing or shrinking the table so the
    // count sweeps between empty and full. The last phase runs without gaps.
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_lock(phase == 2 || phase == 5);
            idle_on = (phase != PHASES - 1) && (phase % 3 != 1);
            repeat (RANDOM_ITEMS / PHASES)
                random_item((phase % 2 == 0) ? 75 : 35);
        end
        write_lock(1'b0);
    endtask

    initial
    begin
        // Reset is applied once, here, and never again.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_lock_register();
        test_full_table();
        test_random_traffic();

        // Let the last results drain, then give the unit time to show any
        // stray done pulse.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("sorted_array_index_unit_tb passed");
        else
            $display("sorted_array_index_unit_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sai_pkg.sv
rtl/core/sai_ram.sv
rtl/core/sai_ctrl.sv
rtl/core/sai_dpath.sv
rtl/core/sorted_array_index_unit.sv
rtl/core/sai_checker.sv
verif/sorted_array_index_unit_tb.sv
